### rtl/core/nrle_pkg.sv
// Package with the shared types and constants of the nibble RLE frame decoder.
`timescale 1ns / 1ps

package nrle_pkg;

  localparam int unsigned MAX_WIDTH   = 320;
  localparam int unsigned MAX_HEIGHT  = 240;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW          = 17;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Input item functions.
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Frame status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_OVERRUN  = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_COPYROW0 = 3'd4;

  // Run kinds, taken from command bits 5:4.
  localparam logic [1:0] KIND_FILL = 2'b00;
  localparam logic [1:0] KIND_LIT  = 2'b01;
  localparam logic [1:0] KIND_SKIP = 2'b10;
  localparam logic [1:0] KIND_COPY = 2'b11;

  // Skip codes that take extension bytes.
  localparam logic [4:0] SKIP_EXT1   = 5'd29;
  localparam logic [4:0] SKIP_EXT257 = 5'd30;
  localparam logic [4:0] SKIP_EXT2   = 5'd31;

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_CMD, PH_EXT1, PH_EXTHI,
    PH_EXTLO, PH_LIT, PH_DONE, PH_ERR
  } phase_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDW, S_BYTE, S_RUN, S_FILL, S_CPR, S_CPW, S_CPN,
    S_LIT2, S_AFTER, S_FIN, S_EMIT
  } eng_e;

  function automatic logic [4:0] skip_code(input logic [7:0] b);
    return {b[6], b[3:0]};
  endfunction

endpackage

### rtl/core/nrle_if.sv
// Channel interfaces of the frame decoder: input items, results and configuration.
`timescale 1ns / 1ps

interface nrle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        last;
  logic [16:0] pixel_addr;
  modport source (output valid, func, data_byte, last, pixel_addr, input ready);
  modport sink (input valid, func, data_byte, last, pixel_addr, output ready);
endinterface

interface nrle_out_if;
  logic       valid;
  logic       ready;
  logic       is_read;
  logic [3:0] pixel_value;
  logic [2:0] status;
  modport source (output valid, is_read, pixel_value, status, input ready);
  modport sink (input valid, is_read, pixel_value, status, output ready);
endinterface

interface nrle_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/nibble_rle_frame_decoder_top.sv
// Top level of the nibble RLE frame decoder with its control sequencer.
`timescale 1ns / 1ps

// Decodes run-length coded frames of 4-bit pixels into a kept 320x240 frame
// store. Pixels live in one synchronous memory written one pixel per cycle.
// After reset, and after every clear item, the block sweeps the whole store to
// zero, during which no item is accepted (configuration writes are still
// taken). A payload byte steps through its phases and then its run: a fill
// writes its pixels in turn, and a copy from the row above reads then writes
// each pixel (through the single memory port pair) and writes one more pixel
// after it. A byte marked last then hands its status to the output register.
// A pixel read goes through the registered memory read, which an address
// beyond the store skips. Each result waits in an output register, so a
// stalled result side holds the block only when the next result is due.
module nibble_rle_frame_decoder_top
  import nrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  nrle_in_if.sink    in_i,
  nrle_out_if.source out_o,
  nrle_cfg_if.sink   cfg_i
);

  eng_e   state_q, state_d;
  phase_e phase_q, phase_d;

  logic [8:0]    cfg_w_q, cfg_h_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] run_q, run_d;
  logic [AW-1:0] total_q, total_d;
  logic [8:0]    stride_q, stride_d;
  logic [23:0]   hdr_q, hdr_d;
  logic [7:0]    pend_q, pend_d;
  logic [1:0]    kind_q, kind_d;
  logic [2:0]    fstat_q, fstat_d;

  // Captured input item.
  logic [7:0]    byte_q;
  logic          last_q;

  // Pending result.
  logic       res_read_q, res_read_d;
  logic [3:0] res_pix_q, res_pix_d;
  logic [2:0] res_stat_q, res_stat_d;

  logic       ovalid_q;
  logic       oread_q;
  logic [3:0] opix_q;
  logic [2:0] ostat_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0]    wdata, rdata;

  logic          in_xfer, out_free;
  logic [AW-1:0] rem, lit_rest;
  logic          over1, over2, cp_row0, addr_oor;
  logic [4:0]    scode;
  logic [15:0]   hw, hh;
  logic          hdr_bad;
  logic [31:0]   hdr_full;

  nrle_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !ovalid_q || out_o.ready;

  assign out_o.valid       = ovalid_q;
  assign out_o.is_read     = oread_q;
  assign out_o.pixel_value = opix_q;
  assign out_o.status      = ostat_q;

  // Shared decisions of the sequencer.
  assign rem      = total_q - wp_q;
  assign over1    = cnt_q > rem;
  assign over2    = cnt_q >= rem;
  assign cp_row0  = wp_q < {{(AW-9){1'b0}}, stride_q};
  assign lit_rest = cnt_q[0] ? cnt_q - AW'(1) : cnt_q;
  assign scode    = skip_code(byte_q);
  assign addr_oor = in_i.pixel_addr >= AW'(STORE_DEPTH);
  assign hdr_full = {hdr_q, byte_q};
  assign hw       = hdr_full[31:16];
  assign hh       = hdr_full[15:0];
  assign hdr_bad  = (hw == 16'd0) || (hh == 16'd0) || (hw > 16'(MAX_WIDTH)) ||
                    (hh > 16'(MAX_HEIGHT)) || (hw != {7'd0, cfg_w_q}) ||
                    (hh != {7'd0, cfg_h_q}) || hw[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(STORE_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.func)
            FUNC_BYTE:  state_d = S_BYTE;
            FUNC_READ:  state_d = addr_oor ? S_EMIT : S_RDW;
            FUNC_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_RDW: state_d = S_EMIT;
      S_BYTE: begin
        unique case (phase_q)
          PH_CMD: begin
            if (!byte_q[7]) begin
              state_d = S_RUN;
            end else if (byte_q[5:4] == KIND_SKIP) begin
              state_d = (scode == SKIP_EXT1 || scode == SKIP_EXT257 ||
                         scode == SKIP_EXT2) ? S_FIN : S_RUN;
            end else begin
              state_d = S_FIN;
            end
          end
          PH_EXT1, PH_EXTLO: state_d = S_RUN;
          PH_LIT:            state_d = S_LIT2;
          default:           state_d = S_FIN;
        endcase
      end
      S_RUN: begin
        if (over1) begin
          state_d = S_FIN;
        end else begin
          unique case (kind_q)
            KIND_FILL: state_d = S_FILL;
            KIND_COPY: state_d = (cp_row0 || over2) ? S_FIN : S_CPR;
            KIND_LIT:  state_d = (lit_rest == '0) ? S_AFTER : S_FIN;
            default:   state_d = S_AFTER;
          endcase
        end
      end
      S_FILL: if (cnt_q == AW'(1)) state_d = S_AFTER;
      S_CPR:  state_d = S_CPW;
      S_CPW:  state_d = (cnt_q == AW'(1)) ? S_CPN : S_CPR;
      S_CPN:  state_d = S_AFTER;
      S_LIT2: state_d = (run_q == AW'(2)) ? S_AFTER : S_FIN;
      S_AFTER: state_d = S_FIN;
      S_FIN:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    phase_d    = phase_q;
    clr_d      = clr_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    total_d    = total_q;
    stride_d   = stride_q;
    hdr_d      = hdr_q;
    pend_d     = pend_q;
    kind_d     = kind_q;
    fstat_d    = fstat_q;
    res_read_d = res_read_q;
    res_pix_d  = res_pix_q;
    res_stat_d = res_stat_q;
    we         = 1'b0;
    waddr      = wp_q;
    wdata      = pend_q[3:0];
    raddr      = in_i.pixel_addr;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = 4'd0;
        clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        clr_d      = '0;
        res_read_d = 1'b1;
        res_pix_d  = 4'd0;
        res_stat_d = ST_OK;
      end
      S_RDW: res_pix_d = rdata;
      S_BYTE: begin
        unique case (phase_q)
          PH_HDR0: begin
            hdr_d   = {16'd0, byte_q};
            phase_d = PH_HDR1;
          end
          PH_HDR1: begin
            hdr_d   = hdr_full[23:0];
            phase_d = PH_HDR2;
          end
          PH_HDR2: begin
            hdr_d   = hdr_full[23:0];
            phase_d = PH_HDR3;
          end
          PH_HDR3: begin
            hdr_d    = hdr_full[23:0];
            stride_d = hw[8:0];
            total_d  = AW'(hw[8:0] * hh[7:0]);
            if (hdr_bad) begin
              fstat_d = ST_SIZE;
              phase_d = PH_ERR;
            end else begin
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            pend_d = byte_q;
            if (!byte_q[7]) begin
              kind_d = KIND_FILL;
              cnt_d  = AW'(byte_q[7:4]) + AW'(1);
            end else begin
              kind_d = byte_q[5:4];
              if (byte_q[5:4] == KIND_SKIP) begin
                if (scode == SKIP_EXT1 || scode == SKIP_EXT257) phase_d = PH_EXT1;
                else if (scode == SKIP_EXT2) phase_d = PH_EXTHI;
                else cnt_d = AW'(scode) + AW'(1);
              end else begin
                phase_d = byte_q[6] ? PH_EXTHI : PH_EXT1;
              end
            end
          end
          PH_EXT1: begin
            if (kind_q == KIND_SKIP && skip_code(pend_q) == SKIP_EXT257) begin
              cnt_d = AW'(byte_q) + AW'(257);
            end else begin
              cnt_d = AW'(byte_q) + AW'(1);
            end
          end
          PH_EXTHI: begin
            run_d   = AW'(byte_q);
            phase_d = PH_EXTLO;
          end
          PH_EXTLO: cnt_d = AW'({run_q[7:0], byte_q}) + AW'(1);
          PH_LIT: begin
            we    = 1'b1;
            wdata = byte_q[7:4];
          end
          default: ;
        endcase
      end
      S_RUN: begin
        if (over1) begin
          fstat_d = ST_OVERRUN;
          phase_d = PH_ERR;
        end else begin
          unique case (kind_q)
            KIND_FILL: ;
            KIND_COPY: begin
              if (cp_row0) begin
                fstat_d = ST_COPYROW0;
                phase_d = PH_ERR;
              end else if (over2) begin
                fstat_d = ST_OVERRUN;
                phase_d = PH_ERR;
              end
            end
            KIND_LIT: begin
              if (cnt_q[0]) begin
                we   = 1'b1;
                wp_d = wp_q + AW'(1);
              end
              if (lit_rest != '0) begin
                run_d   = lit_rest;
                phase_d = PH_LIT;
              end
            end
            default: wp_d = wp_q + cnt_q;
          endcase
        end
      end
      S_FILL: begin
        we    = 1'b1;
        wp_d  = wp_q + AW'(1);
        cnt_d = cnt_q - AW'(1);
      end
      S_CPR: raddr = wp_q - {{(AW-9){1'b0}}, stride_q};
      S_CPW: begin
        we    = 1'b1;
        wdata = rdata;
        wp_d  = wp_q + AW'(1);
        cnt_d = cnt_q - AW'(1);
      end
      S_CPN: begin
        we   = 1'b1;
        wp_d = wp_q + AW'(1);
      end
      S_LIT2: begin
        we    = 1'b1;
        waddr = wp_q + AW'(1);
        wdata = byte_q[3:0];
        wp_d  = wp_q + AW'(2);
        run_d = run_q - AW'(2);
      end
      S_AFTER: phase_d = (wp_q >= total_q) ? PH_DONE : PH_CMD;
      S_FIN: begin
        if (last_q) begin
          res_read_d = 1'b0;
          res_pix_d  = 4'd0;
          res_stat_d = (phase_q != PH_DONE && phase_q != PH_ERR) ? ST_TRUNC : fstat_q;
          phase_d    = PH_HDR0;
          wp_d       = '0;
          run_d      = '0;
          fstat_d    = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      phase_q  <= PH_HDR0;
      clr_q    <= '0;
      wp_q     <= '0;
      cnt_q    <= '0;
      run_q    <= '0;
      hdr_q    <= '0;
      pend_q   <= '0;
      fstat_q  <= ST_OK;
      ovalid_q <= 1'b0;
      cfg_w_q  <= 9'(MAX_WIDTH);
      cfg_h_q  <= 9'(MAX_HEIGHT);
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      hdr_q   <= hdr_d;
      pend_q  <= pend_d;
      fstat_q <= fstat_d;
      if (state_q == S_EMIT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      // Configuration transfer.
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_WIDTH) cfg_w_q <= cfg_i.data;
        else if (cfg_i.index == CFG_HEIGHT) cfg_h_q <= {1'b0, cfg_i.data[7:0]};
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    total_q    <= total_d;
    stride_q   <= stride_d;
    kind_q     <= kind_d;
    res_read_q <= res_read_d;
    res_pix_q  <= res_pix_d;
    res_stat_q <= res_stat_d;
    if (in_xfer) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last;
    end
    if (state_q == S_EMIT && out_free) begin
      oread_q <= res_read_q;
      opix_q  <= res_pix_q;
      ostat_q <= res_stat_q;
    end
  end

endmodule

### rtl/core/nrle_store.sv
// Frame store: single write port, single read port with registered read data.
`timescale 1ns / 1ps

module nrle_store
  import nrle_pkg::*;
(
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);

  logic [3:0] mem [STORE_DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
